// ----- rtl/kdslp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdslp_pkg: shared types and constants of the key debounce block
// Key count, field widths, register indexes, event codes and the
// configuration and result types used by the lanes, the merge stage
// and the top level.
// ----------------------------------------------------------------------------
package kdslp_pkg;

  // Number of debounced keys (one lane each).
  localparam int NUM_KEYS   = 4;
  // Width of the raw level field and number of event fields in a result.
  localparam int KEY_IN_W   = 4;
  localparam int OUT_FIELDS = 4;

  localparam int DTICK_W    = 4;
  localparam int LTICK_W    = 16;
  localparam int EV_W       = 2;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = CFG_IDX_W'(1);

  localparam logic [DTICK_W-1:0] DEBOUNCE_TICKS_RST = DTICK_W'(2);
  localparam logic [LTICK_W-1:0] LONG_TICKS_RST     = LTICK_W'(100);

  typedef enum logic [EV_W-1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_code_t;

  typedef struct packed {
    logic [DTICK_W-1:0] debounce_ticks;
    logic [LTICK_W-1:0] long_ticks;
  } cfg_t;

  typedef logic [OUT_FIELDS-1:0][EV_W-1:0] result_t;

endpackage

// ----- rtl/kdslp_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdslp_ifs: channel interfaces of the key debounce block
// Scan tick input channel, event result channel and the configuration
// write channel, each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface kdslp_key_if
  import kdslp_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [KEY_IN_W-1:0] key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

interface kdslp_event_if
  import kdslp_pkg::*;
  ;
  logic            valid;
  logic            ready;
  logic [EV_W-1:0] key0_evt;
  logic [EV_W-1:0] key1_evt;
  logic [EV_W-1:0] key2_evt;
  logic [EV_W-1:0] key3_evt;

  modport source (output valid, output key0_evt, output key1_evt,
                  output key2_evt, output key3_evt, input ready);
  modport sink   (input valid, input key0_evt, input key1_evt,
                  input key2_evt, input key3_evt, output ready);
endinterface

interface kdslp_cfg_if
  import kdslp_pkg::*;
  ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/key_debounce_short_long_press_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_short_long_press_core: four-key debouncer with press timing
// Usage notes:
//   keys   : one transfer per scan tick, carrying the raw pressed level of
//            each key (bit i set means key i is pressed).
//   events : one transfer per scan tick, with one event code per key:
//            none, short press or long press. Events are one-tick pulses.
//   cfg    : register writes (0 debounce_ticks, 1 long_ticks); always
//            ready, writes to other indexes are dropped. Write only while
//            no tick is in flight.
//   Result: a tick's result is registered into the output buffer as its transfer completes.
//   Throughput: one tick per cycle while keys.ready is high; each key has its
//            own lane, so the lane update sets the pace.
//   Reset (synchronous rst): all keys released, counters cleared,
//            debounce_ticks = 2, long_ticks = 100, output buffer empty.
//   Stall: a two-entry output buffer lets one more tick in while a result
//            waits; after that keys.ready stays low until a waiting result
//            has been transferred, and rises again on the following cycle.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press_core
  import kdslp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  kdslp_key_if.sink     keys,
  kdslp_event_if.source events,
  kdslp_cfg_if.sink     cfg
);

  // Configuration registers.
  cfg_t        cfg_regs;
  logic        tick;
  logic        in_ready;
  event_code_t lane_ev [NUM_KEYS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.debounce_ticks <= DEBOUNCE_TICKS_RST;
      cfg_regs.long_ticks     <= LONG_TICKS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE_TICKS: begin
          cfg_regs.debounce_ticks <= cfg.data[DTICK_W-1:0];
        end
        REG_LONG_TICKS: begin
          cfg_regs.long_ticks <= cfg.data[LTICK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A scan tick advances every lane when its transfer completes.
  assign keys.ready = in_ready;
  assign tick       = keys.valid && in_ready;

  // One lane per key. Keys beyond the input field read as released.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic raw;
    if (k < KEY_IN_W) begin : g_in
      assign raw = keys.key_levels[k];
    end else begin : g_off
      assign raw = 1'b0;
    end

    kdslp_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .tick (tick),
      .raw  (raw),
      .cfg  (cfg_regs),
      .ev   (lane_ev[k])
    );
  end

  // Merge the lane events into one result and buffer it toward the sink.
  kdslp_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (tick),
    .lane_ev  (lane_ev),
    .in_ready (in_ready),
    .res      (events)
  );

endmodule

// ----- rtl/kdslp_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdslp_lane: debounce and press timing for one key
// Holds the accepted level, the debounce run counter and the hold counter
// of one key, and reports the event that the current tick causes.
// ----------------------------------------------------------------------------
module kdslp_lane
  import kdslp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        raw,
  input  cfg_t        cfg,
  output event_code_t ev
);

  logic               stable;
  logic               stable_next;
  logic [DTICK_W-1:0] dcount;
  logic [DTICK_W-1:0] dcount_next;
  logic [LTICK_W-1:0] hold;
  logic [LTICK_W-1:0] hold_next;

  logic               differ;
  logic [DTICK_W-1:0] dcount_inc;
  logic               take_level;
  logic               short_hit;
  logic [LTICK_W-1:0] hold_base;
  logic [LTICK_W-1:0] hold_inc;
  logic               counting;
  logic               long_hit;

  always_comb begin
    differ      = (raw != stable);
    dcount_inc  = dcount + DTICK_W'(1);
    take_level  = differ && (dcount_inc >= cfg.debounce_ticks);
    stable_next = take_level ? raw : stable;
    dcount_next = (differ && !take_level) ? dcount_inc : '0;

    // A release that ends a press shorter than the long threshold.
    short_hit = take_level && !raw && (hold != '0) && (hold < cfg.long_ticks);

    hold_base = take_level ? '0 : hold;
    hold_inc  = hold_base + LTICK_W'(1);
    counting  = stable_next && (hold_base < cfg.long_ticks);
    hold_next = counting ? hold_inc : hold_base;
    long_hit  = counting && (hold_inc == cfg.long_ticks);

    if (long_hit) begin
      ev = EV_LONG;
    end else if (short_hit) begin
      ev = EV_SHORT;
    end else begin
      ev = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      dcount <= '0;
      hold   <= '0;
    end else if (tick) begin
      stable <= stable_next;
      dcount <= dcount_next;
      hold   <= hold_next;
    end
  end

endmodule

// ----- rtl/kdslp_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdslp_merge: gathers the lane events into one result and buffers it
// Packs the per-key events into a result word and holds it in a two-entry
// output buffer (main register plus skid register) toward the receiver.
// ----------------------------------------------------------------------------
module kdslp_merge
  import kdslp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  event_code_t   lane_ev [NUM_KEYS],
  output logic          in_ready,
  kdslp_event_if.source res
);

  result_t result;
  result_t main_word;
  result_t skid_word;
  logic    main_valid;
  logic    skid_valid;
  logic    pop;

  for (genvar k = 0; k < OUT_FIELDS; k++) begin : g_field
    if (k < NUM_KEYS) begin : g_used
      assign result[k] = lane_ev[k];
    end else begin : g_unused
      assign result[k] = EV_NONE;
    end
  end

  assign pop      = main_valid && res.ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_word <= skid_valid ? skid_word : result;
    end else if (push && !main_valid) begin
      main_word <= result;
    end
    if (push && main_valid && !pop) begin
      skid_word <= result;
    end
  end

  assign res.valid    = main_valid;
  assign res.key0_evt = main_word[0];
  assign res.key1_evt = main_word[1];
  assign res.key2_evt = main_word[2];
  assign res.key3_evt = main_word[3];

  // The skid register is only ever filled behind a full main register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held while main register empty");

  // A waiting skid entry moves into the main register when it drains.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && skid_valid) |=> (main_valid && !skid_valid))
    else $error("skid entry lost on drain");

  // A transfer into an empty buffer lands in the main register.
  a_fill_main: assert property (@(posedge clk) disable iff (rst)
    (push && !main_valid) |=> (main_valid && !skid_valid))
    else $error("result not captured in main register");

  // A transfer behind a stalled result is parked in the skid register.
  a_fill_skid: assert property (@(posedge clk) disable iff (rst)
    (push && main_valid && !res.ready) |=> skid_valid)
    else $error("result lost while receiver stalled");

endmodule
